// ----- hdl/bad_pkg.sv -----
`default_nettype none

package bad_pkg;

	localparam int COORD_BITS     = 12;
	localparam int ROTATION_STEPS = 16;
	localparam int TABLE_LEN      = 24;
	localparam int STEPS          = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
	localparam int STEP_W         = $clog2(TABLE_LEN);

	localparam int GUARD_BITS = 28;
	localparam int ANG_FRAC   = 20;
	localparam int OUT_SHIFT  = 14;

	// x/y carry |d| << GUARD_BITS plus CORDIC gain and sign
	localparam int XY_W    = COORD_BITS + GUARD_BITS + 3;
	// angle accumulator, 2^-20 degree, signed, range +/-256 degrees
	localparam int Z_W     = ANG_FRAC + 9;
	// mapped angle 0..360 degrees in 2^-20 degree
	localparam int FINE_W  = ANG_FRAC + 9;
	localparam int ANGLE_W = 15;
	localparam int RND_W   = FINE_W + 1 - OUT_SHIFT;

	localparam logic signed [Z_W-1:0]  QUARTER_Z   = Z_W'(64'd90 << ANG_FRAC);
	localparam logic [FINE_W-1:0]      HALF_TURN   = FINE_W'(64'd180 << ANG_FRAC);
	localparam logic [FINE_W-1:0]      FULL_TURN   = FINE_W'(64'd360 << ANG_FRAC);
	localparam logic [FINE_W:0]        ROUND_HALF  = (FINE_W+1)'(64'd1 << (OUT_SHIFT - 1));
	localparam logic [RND_W-1:0]       FULL_TURN_OUT = RND_W'(23040);

	typedef struct packed {
		logic [COORD_BITS-1:0] ref_x;
		logic [COORD_BITS-1:0] ref_y;
		logic [COORD_BITS-1:0] target_x;
		logic [COORD_BITS-1:0] target_y;
	} pts_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               coincident;
	} bearing_t;

	// quadrant and special-case flags riding along the chain
	typedef struct packed {
		logic coinc;
		logic lower;   // ref_y <= target_y
		logic left;    // ref_x >= target_x
	} side_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		side_t                  side;
	} cordic_t;

	typedef struct packed {
		logic [FINE_W-1:0] fine;
		logic              coinc;
	} fine_t;

	// atan(2^-i) in 2^-20 degree, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:    r = Z_W'(47185920);
			5'd1:    r = Z_W'(27855475);
			5'd2:    r = Z_W'(14718068);
			5'd3:    r = Z_W'(7471121);
			5'd4:    r = Z_W'(3750058);
			5'd5:    r = Z_W'(1876857);
			5'd6:    r = Z_W'(938658);
			5'd7:    r = Z_W'(469357);
			5'd8:    r = Z_W'(234682);
			5'd9:    r = Z_W'(117342);
			5'd10:   r = Z_W'(58671);
			5'd11:   r = Z_W'(29335);
			5'd12:   r = Z_W'(14668);
			5'd13:   r = Z_W'(7334);
			5'd14:   r = Z_W'(3667);
			5'd15:   r = Z_W'(1833);
			5'd16:   r = Z_W'(917);
			5'd17:   r = Z_W'(458);
			5'd18:   r = Z_W'(229);
			5'd19:   r = Z_W'(115);
			5'd20:   r = Z_W'(57);
			5'd21:   r = Z_W'(29);
			5'd22:   r = Z_W'(14);
			5'd23:   r = Z_W'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/bearing_angle_degrees.sv -----
`default_nettype none

// Bearing from a reference point to a target point in screen coordinates
// (y grows downward), as an angle counter-clockwise from +x in 1/64 degree,
// 0..23039; equal points give angle 0 with coincident set. The datapath is
// a fully pipelined chain: one input register, STEPS CORDIC cells (16 by
// default), a clamp/quadrant stage and a rounding output register. One
// transaction is taken every cycle while the output side keeps up. Each
// stage has its own valid bit and advances whenever it is empty or the
// stage after it advances, so bubbles close up and the chain keeps filling
// while a finished result is held under bearing_stall. No state is carried
// between transactions and there is nothing to configure.

module bearing_angle_degrees import bad_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pts_valid,
	output logic          pts_stall,
	input  wire pts_t     pts,
	output logic          bearing_valid,
	input  wire logic     bearing_stall,
	output bearing_t      bearing
);

	// stage 0: front, 1..STEPS: cells, STEPS+1: map, STEPS+2: output
	localparam int NSTG = STEPS + 3;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] ld;
	cordic_t         chain [STEPS+1];

	// load-enable ripple from the output back to the input
	always_comb begin
		ld[NSTG-1] = !vld_q[NSTG-1] || !bearing_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= pts_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	bad_front u_front (
		.clk  (clk),
		.ld   (ld[0]),
		.din  (pts),
		.dout (chain[0])
	);

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		bad_cell u_cell (
			.clk  (clk),
			.ld   (ld[g+1]),
			.step (STEP_W'(g)),
			.din  (chain[g]),
			.dout (chain[g+1])
		);
	end

	bad_back u_back (
		.clk  (clk),
		.ld1  (ld[NSTG-2]),
		.ld2  (ld[NSTG-1]),
		.din  (chain[STEPS]),
		.dout (bearing)
	);

	assign pts_stall     = !ld[0];
	assign bearing_valid = vld_q[NSTG-1];

endmodule

`default_nettype wire

// ----- hdl/bad_front.sv -----
`default_nettype none

module bad_front import bad_pkg::*; (
	input  wire logic    clk,
	input  wire logic    ld,
	input  wire pts_t    din,
	output cordic_t      dout
);

	logic signed [COORD_BITS:0] dx, up;
	logic [COORD_BITS-1:0]      adx, aup;
	cordic_t                    nxt;
	cordic_t                    cell_s0;

	always_comb begin
		dx  = $signed({1'b0, din.target_x}) - $signed({1'b0, din.ref_x});
		up  = $signed({1'b0, din.ref_y}) - $signed({1'b0, din.target_y});
		adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		aup = up[COORD_BITS] ? COORD_BITS'(-up) : up[COORD_BITS-1:0];
		nxt.x = $signed(XY_W'({adx, {GUARD_BITS{1'b0}}}));
		nxt.y = $signed(XY_W'({aup, {GUARD_BITS{1'b0}}}));
		nxt.z = '0;
		nxt.side.coinc = (din.ref_x == din.target_x) && (din.ref_y == din.target_y);
		nxt.side.lower = (din.ref_y <= din.target_y);
		nxt.side.left  = (din.ref_x >= din.target_x);
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			cell_s0 <= nxt;
		end
	end

	assign dout = cell_s0;

endmodule

`default_nettype wire

// ----- hdl/bad_cell.sv -----
`default_nettype none

// one vectoring micro-rotation; shift and table entry chosen by step
module bad_cell import bad_pkg::*; (
	input  wire logic              clk,
	input  wire logic              ld,
	input  wire logic [STEP_W-1:0] step,
	input  wire cordic_t           din,
	output cordic_t                dout
);

	logic signed [XY_W-1:0] xs, ys;
	cordic_t                nxt;
	cordic_t                rot_q;

	always_comb begin
		xs  = din.x >>> step;
		ys  = din.y >>> step;
		nxt = din;
		if (din.y > 0) begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + atan_entry(step);
		end else begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - atan_entry(step);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rot_q <= nxt;
		end
	end

	assign dout = rot_q;

endmodule

`default_nettype wire

// ----- hdl/bad_back.sv -----
`default_nettype none

// clamp + quadrant map, then round to 1/64 degree with wrap
module bad_back import bad_pkg::*; (
	input  wire logic    clk,
	input  wire logic    ld1,
	input  wire logic    ld2,
	input  wire cordic_t din,
	output bearing_t     dout
);

	logic [FINE_W-1:0] theta;
	fine_t             map_n;
	fine_t             map_s1;
	logic [FINE_W:0]   sum;
	logic [RND_W-1:0]  ang;
	bearing_t          res_n;
	bearing_t          res_s2;

	always_comb begin
		if (din.z < 0) begin
			theta = '0;
		end else if (din.z > QUARTER_Z) begin
			theta = FINE_W'(QUARTER_Z);
		end else begin
			theta = FINE_W'(din.z);
		end
		case ({din.side.lower, din.side.left})
			2'b11:   map_n.fine = HALF_TURN + theta;
			2'b10:   map_n.fine = FULL_TURN - theta;
			2'b01:   map_n.fine = HALF_TURN - theta;
			default: map_n.fine = theta;
		endcase
		map_n.coinc = din.side.coinc;
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			map_s1 <= map_n;
		end
	end

	always_comb begin
		sum = {1'b0, map_s1.fine} + ROUND_HALF;
		ang = sum[FINE_W:OUT_SHIFT];
		if (ang >= FULL_TURN_OUT) begin
			ang = ang - FULL_TURN_OUT;
		end
		if (map_s1.coinc) begin
			res_n.angle      = '0;
			res_n.coincident = 1'b1;
		end else begin
			res_n.angle      = ang[ANGLE_W-1:0];
			res_n.coincident = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			res_s2 <= res_n;
		end
	end

	assign dout = res_s2;

endmodule

`default_nettype wire

// ----- hdl/bad_chk.sv -----
`default_nettype none

module bad_chk import bad_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     pts_stall,
	input wire logic     bearing_valid,
	input wire logic     bearing_stall,
	input wire bearing_t bearing
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bearing_valid && bearing_stall |=> bearing_valid && $stable(bearing))
		else $error("bearing changed while stalled");

	a_coinc: assert property (@(posedge clk) disable iff (!arst_n)
		bearing_valid && bearing.coincident |-> bearing.angle == '0)
		else $error("coincident points with nonzero angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		bearing_valid |-> bearing.angle < ANGLE_W'(23040))
		else $error("angle not wrapped below a full turn");

	a_rst: assert property (@(posedge clk)
		!arst_n |-> !bearing_valid)
		else $error("result valid during reset");

	// input only backs up when the output is held
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		pts_stall |-> bearing_valid && bearing_stall)
		else $error("input stalled with the output free");

endmodule

bind bearing_angle_degrees bad_chk u_chk (.*);

`default_nettype wire
